### sv/triangle_zbuffer_pixel_test_top_defines.svh
// Assertion macros shared by the triangle z-buffer pixel test block.
// Depends on nothing; included by the modules that carry assertions.
`ifndef TRIANGLE_ZBUFFER_PIXEL_TEST_TOP_DEFINES_SVH
`define TRIANGLE_ZBUFFER_PIXEL_TEST_TOP_DEFINES_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define TZB_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Check that the consequent holds in the cycle after the antecedent.
`define TZB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### sv/tzb_pkg.sv
// Shared widths, item layout and state encodings of the triangle z-buffer pixel test.
// Used by every module of the block; depends on nothing.
package tzb_pkg;

   localparam int COORD_W = 12;
   localparam int Z_W     = 8;
   localparam int COLOR_W = 32;
   localparam int PIX_W   = 8;
   localparam int DIFF_W  = COORD_W + 1;
   // doubled signed areas stay below 2^25 in magnitude
   localparam int AREA_W  = 27;
   localparam int ACC_W   = 36;
   // weighted depth sum is below 256 times the area
   localparam int NUM_W   = 34;
   localparam int TERM_W  = 2;
   localparam int CNT_W   = $clog2(Z_W);

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 56;

   localparam int TZB_SCREEN_WIDTH  = 256;
   localparam int TZB_SCREEN_HEIGHT = 256;
   localparam int TZB_DEPTH         = TZB_SCREEN_WIDTH * TZB_SCREEN_HEIGHT;

   localparam logic [TERM_W-1:0] TERM_FIRST = 2'd0;
   localparam logic [TERM_W-1:0] TERM_MID   = 2'd1;
   localparam logic [TERM_W-1:0] TERM_LAST  = 2'd2;

   // One input word, last declared field (vert_a_x) in the lowest bits.
   typedef struct packed {
      logic        [PIX_W-1:0]   pixel_y;
      logic        [PIX_W-1:0]   pixel_x;
      logic        [COLOR_W-1:0] fill_color;
      logic        [Z_W-1:0]     vert_c_z;
      logic signed [COORD_W-1:0] vert_c_y;
      logic signed [COORD_W-1:0] vert_c_x;
      logic        [Z_W-1:0]     vert_b_z;
      logic signed [COORD_W-1:0] vert_b_y;
      logic signed [COORD_W-1:0] vert_b_x;
      logic        [Z_W-1:0]     vert_a_z;
      logic signed [COORD_W-1:0] vert_a_y;
      logic signed [COORD_W-1:0] vert_a_x;
   } tzb_item_type;

   typedef enum logic [2:0] {
      GP_IDLE,
      GP_TOTAL,
      GP_DA,
      GP_DB,
      GP_NORM,
      GP_NUM,
      GP_DONE
   } geom_phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_GEOM,
      ST_DIV,
      ST_OUT
   } tzb_state_type;

endpackage

### sv/triangle_zbuffer_pixel_test_top.sv
// Top level of the triangle z-buffer pixel test: control, bounding box and result register.
// Depends on tzb_pkg, tzb_geom, tzb_div, tzb_zmem and the assertion macros.
//
//   Channel  Dir  Handshake              Payload
//   req      in   req_tvalid/req_tready  req_tdata: triangle, color, pixel (144 bits)
//   rsp      out  rsp_tvalid/rsp_tready  rsp_tdata: x, y, depth, color; rsp_tuser: write
//
// One pixel at a time; a pixel that misses skips the divider.
// Area and depth sums share one multiply-accumulate unit, followed by a done strobe;
// the quotient then takes 8 restoring steps and the done strobe.
// After reset the depth store is swept to zero, with req_tready low. A stalled
// result holds in the output register while the next pixel is taken and worked on.
`include "triangle_zbuffer_pixel_test_top_defines.svh"

module triangle_zbuffer_pixel_test_top
   import tzb_pkg::*;
#(
   parameter int SCREEN_WIDTH  = TZB_SCREEN_WIDTH,
   parameter int SCREEN_HEIGHT = TZB_SCREEN_HEIGHT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
   // vert_c_x, vert_c_y, vert_c_z, fill_color, pixel_x, pixel_y
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // out_x, out_y, out_depth, out_color
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   // write_pixel
   output logic                  rsp_tuser
);

   localparam int DEPTH  = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W = $clog2(DEPTH);

   tzb_state_type state_ff, state_in;
   tzb_item_type  item_ff;

   logic               hit_ff;
   logic [Z_W-1:0]     depth_ff;
   logic               rsp_valid_ff;
   logic               rsp_write_ff;
   logic [PIX_W-1:0]   rsp_x_ff, rsp_y_ff;
   logic [Z_W-1:0]     rsp_depth_ff;
   logic [COLOR_W-1:0] rsp_color_ff;

   logic                      accept;
   logic                      out_load;
   logic signed [COORD_W-1:0] pix_x, pix_y;
   logic                      in_box, on_screen, hit_geom, nearer;
   logic [ADDR_W-1:0]         addr;

   logic              geom_done, geom_covered;
   logic [AREA_W-2:0] geom_total;
   logic [NUM_W-1:0]  geom_num;
   logic              div_start, div_done;
   logic [Z_W-1:0]    div_quo;
   logic              mem_rd_en, mem_wr_en, mem_ready;
   logic [Z_W-1:0]    mem_rd_data;

   assign accept = req_tvalid && req_tready;

   // Bounding box with upper edges excluded, and the screen limits
   assign pix_x = $signed({{(COORD_W-PIX_W){1'b0}}, item_ff.pixel_x});
   assign pix_y = $signed({{(COORD_W-PIX_W){1'b0}}, item_ff.pixel_y});
   assign in_box =
      (pix_x >= item_ff.vert_a_x || pix_x >= item_ff.vert_b_x || pix_x >= item_ff.vert_c_x) &&
      (pix_x <  item_ff.vert_a_x || pix_x <  item_ff.vert_b_x || pix_x <  item_ff.vert_c_x) &&
      (pix_y >= item_ff.vert_a_y || pix_y >= item_ff.vert_b_y || pix_y >= item_ff.vert_c_y) &&
      (pix_y <  item_ff.vert_a_y || pix_y <  item_ff.vert_b_y || pix_y <  item_ff.vert_c_y);
   assign on_screen = (32'(item_ff.pixel_x) < 32'(SCREEN_WIDTH)) &&
                      (32'(item_ff.pixel_y) < 32'(SCREEN_HEIGHT));
   assign addr = ADDR_W'(ADDR_W'(item_ff.pixel_y) * ADDR_W'(SCREEN_WIDTH)
                 + ADDR_W'(item_ff.pixel_x));

   assign hit_geom = geom_covered && in_box && on_screen;
   assign nearer   = (div_quo > mem_rd_data);

   tzb_geom u_geom (
      .clock   (clock),
      .reset   (reset),
      .start   (accept),
      .item    (item_ff),
      .done    (geom_done),
      .covered (geom_covered),
      .total   (geom_total),
      .num     (geom_num)
   );

   tzb_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (geom_num),
      .den   (geom_total),
      .done  (div_done),
      .quo   (div_quo)
   );

   tzb_zmem #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_zmem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_addr (addr),
      .rd_data (mem_rd_data),
      .wr_en   (mem_wr_en),
      .wr_addr (addr),
      .wr_data (div_quo),
      .ready   (mem_ready)
   );

   // Next state and control strobes
   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      mem_rd_en  = 1'b0;
      mem_wr_en  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         ST_CLEAR: if (mem_ready) state_in = ST_IDLE;
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) state_in = ST_GEOM;
         end
         ST_GEOM: begin
            mem_rd_en = on_screen;
            if (geom_done) begin
               div_start = hit_geom;
               state_in  = hit_geom ? ST_DIV : ST_OUT;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               mem_wr_en = nearer;
               state_in  = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_CLEAR;
      else       state_ff <= state_in;
   end

   // Hold the item and the write decision
   always_ff @(posedge clock) begin
      if (accept) item_ff <= tzb_item_type'(req_tdata);
      if (state_ff == ST_GEOM && geom_done && !hit_geom) hit_ff <= 1'b0;
      if (state_ff == ST_DIV && div_done) begin
         hit_ff   <= nearer;
         depth_ff <= div_quo;
      end
   end

   // Result register: load when empty or drained, drop when taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         rsp_write_ff <= hit_ff;
         rsp_x_ff     <= hit_ff ? item_ff.pixel_x : '0;
         rsp_y_ff     <= hit_ff ? item_ff.pixel_y : '0;
         rsp_depth_ff <= hit_ff ? depth_ff : '0;
         rsp_color_ff <= hit_ff ? item_ff.fill_color : '0;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_write_ff;
   assign rsp_tdata  = {rsp_color_ff, rsp_depth_ff, rsp_y_ff, rsp_x_ff};

   `TZB_ASSERT_SAME(a_no_take_in_clear, clock, reset, !mem_ready, !req_tready, "pixel taken during clear")
   `TZB_ASSERT_SAME(a_write_depth_nonzero, clock, reset, rsp_valid_ff && rsp_write_ff, rsp_depth_ff != '0, "written depth not above cleared store")
   `TZB_ASSERT_SAME(a_miss_fields_zero, clock, reset, rsp_valid_ff && !rsp_write_ff, rsp_tdata == '0, "miss word carries nonzero fields")
   `TZB_ASSERT_NEXT(a_one_at_a_time, clock, reset, accept, !req_tready, "second pixel taken while busy")

endmodule

### sv/tzb_geom.sv
// Area and weighted-depth sequencer: one shared multiply-accumulate unit.
// Depends on tzb_pkg.
module tzb_geom
   import tzb_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  tzb_item_type             item,
   output logic                     done,
   output logic                     covered,
   output logic [AREA_W-2:0]        total,
   output logic [NUM_W-1:0]         num
);

   geom_phase_type phase_ff, phase_in;
   logic [TERM_W-1:0] term_ff, term_in;

   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [AREA_W-1:0] total_ff, da_ff, db_ff, dc_ff;
   logic [NUM_W-1:0]         num_ff;
   logic                     covered_ff;

   logic signed [COORD_W-1:0] pix_x, pix_y;
   logic signed [COORD_W-1:0] p_x, p_y, q_x, q_y, r_x, r_y, m_x;
   logic signed [DIFF_W-1:0]  diff;
   logic [Z_W-1:0]            z_sel;
   logic signed [AREA_W-1:0]  area_sel;
   logic signed [AREA_W-1:0]  mul_a;
   logic signed [DIFF_W-1:0]  mul_b;
   logic signed [AREA_W+DIFF_W-1:0] prod;
   logic signed [ACC_W-1:0]   acc_sum;
   logic                      is_mac;
   logic                      neg;
   logic signed [AREA_W-1:0]  n_total, n_da, n_db, n_dc;

   assign pix_x = $signed({{(COORD_W-PIX_W){1'b0}}, item.pixel_x});
   assign pix_y = $signed({{(COORD_W-PIX_W){1'b0}}, item.pixel_y});

   // Pick the vertices of the current area and the term's operands
   always_comb begin
      p_x = item.vert_a_x;
      p_y = item.vert_a_y;
      q_x = item.vert_b_x;
      q_y = item.vert_b_y;
      r_x = item.vert_c_x;
      r_y = item.vert_c_y;
      if (phase_ff == GP_DA) begin
         p_x = pix_x;
         p_y = pix_y;
      end
      if (phase_ff == GP_DB) begin
         q_x = pix_x;
         q_y = pix_y;
      end
      case (term_ff)
         TERM_FIRST: begin
            m_x   = r_x;
            diff  = $signed({q_y[COORD_W-1], q_y}) - $signed({p_y[COORD_W-1], p_y});
            z_sel = item.vert_a_z;
            area_sel = da_ff;
         end
         TERM_MID: begin
            m_x   = q_x;
            diff  = $signed({p_y[COORD_W-1], p_y}) - $signed({r_y[COORD_W-1], r_y});
            z_sel = item.vert_b_z;
            area_sel = db_ff;
         end
         TERM_LAST: begin
            m_x   = p_x;
            diff  = $signed({r_y[COORD_W-1], r_y}) - $signed({q_y[COORD_W-1], q_y});
            z_sel = item.vert_c_z;
            area_sel = dc_ff;
         end
         default: begin
            m_x   = '0;
            diff  = '0;
            z_sel = '0;
            area_sel = '0;
         end
      endcase
      if (phase_ff == GP_NUM) begin
         mul_a = area_sel;
         mul_b = $signed({{(DIFF_W-Z_W){1'b0}}, z_sel});
      end else begin
         mul_a = $signed({{(AREA_W-COORD_W){m_x[COORD_W-1]}}, m_x});
         mul_b = diff;
      end
   end

   // Multiply and accumulate, restarting on the first term
   assign prod    = mul_a * mul_b;
   assign acc_sum = ((term_ff == TERM_FIRST) ? ACC_W'(0) : acc_ff) + $signed(prod[ACC_W-1:0]);

   // Orient the areas so the total is not negative; the third area follows from the sum
   assign neg     = total_ff[AREA_W-1];
   assign n_total = neg ? -total_ff : total_ff;
   assign n_da    = neg ? -da_ff : da_ff;
   assign n_db    = neg ? -db_ff : db_ff;
   assign n_dc    = n_total - n_da - n_db;

   // Sequence the phases
   always_comb begin
      phase_in = phase_ff;
      is_mac   = 1'b0;
      case (phase_ff)
         GP_IDLE:  if (start) phase_in = GP_TOTAL;
         GP_TOTAL: begin
            is_mac = 1'b1;
            if (term_ff == TERM_LAST) phase_in = GP_DA;
         end
         GP_DA: begin
            is_mac = 1'b1;
            if (term_ff == TERM_LAST) phase_in = GP_DB;
         end
         GP_DB: begin
            is_mac = 1'b1;
            if (term_ff == TERM_LAST) phase_in = GP_NORM;
         end
         GP_NORM:  phase_in = GP_NUM;
         GP_NUM: begin
            is_mac = 1'b1;
            if (term_ff == TERM_LAST) phase_in = GP_DONE;
         end
         GP_DONE:  phase_in = GP_IDLE;
         default:  phase_in = GP_IDLE;
      endcase
      term_in = (is_mac && term_ff != TERM_LAST) ? term_ff + 1'b1 : TERM_FIRST;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= GP_IDLE;
         term_ff  <= TERM_FIRST;
      end else begin
         phase_ff <= phase_in;
         term_ff  <= term_in;
      end
   end

   // Capture each area and the depth sum at the end of its phase
   always_ff @(posedge clock) begin
      acc_ff <= acc_sum;
      case (phase_ff)
         GP_TOTAL: if (term_ff == TERM_LAST) total_ff <= acc_sum[AREA_W-1:0];
         GP_DA:    if (term_ff == TERM_LAST) da_ff <= acc_sum[AREA_W-1:0];
         GP_DB:    if (term_ff == TERM_LAST) db_ff <= acc_sum[AREA_W-1:0];
         GP_NORM: begin
            total_ff   <= n_total;
            da_ff      <= n_da;
            db_ff      <= n_db;
            dc_ff      <= n_dc;
            covered_ff <= (total_ff != '0) && !n_da[AREA_W-1] && !n_db[AREA_W-1]
                          && !n_dc[AREA_W-1];
         end
         GP_NUM:   if (term_ff == TERM_LAST) num_ff <= acc_sum[NUM_W-1:0];
         default: ;
      endcase
   end

   assign done    = (phase_ff == GP_DONE);
   assign covered = covered_ff;
   assign total   = total_ff[AREA_W-2:0];
   assign num     = num_ff;

endmodule

### sv/tzb_div.sv
// Restoring divider for the depth quotient, one quotient bit per cycle.
// Depends on tzb_pkg and the block's assertion macros.
`include "triangle_zbuffer_pixel_test_top_defines.svh"

module tzb_div
   import tzb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [AREA_W-2:0] den,
   output logic              done,
   output logic [Z_W-1:0]    quo
);

   logic             busy_ff;
   logic             done_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [NUM_W-1:0] rem_ff;
   logic [NUM_W-1:0] sub_ff;
   logic [Z_W-1:0]   quo_ff;
   logic             fits;

   assign fits = (rem_ff >= sub_ff);

   // Track the busy window and the bit count
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(Z_W - 1);
         end else if (busy_ff) begin
            if (cnt_ff == '0) busy_ff <= 1'b0;
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // Subtract the shifted divisor where it fits, most significant bit first
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= num;
         sub_ff <= NUM_W'(den) << (Z_W - 1);
         quo_ff <= '0;
      end else if (busy_ff) begin
         if (fits) rem_ff <= rem_ff - sub_ff;
         sub_ff <= sub_ff >> 1;
         quo_ff <= {quo_ff[Z_W-2:0], fits};
      end
   end

   assign done = done_ff;
   assign quo  = quo_ff;

   `TZB_ASSERT_SAME(a_div_start_idle, clock, reset, start, !busy_ff, "divider started while busy")

endmodule

### sv/tzb_zmem.sv
// Depth store: single-port-write, registered-read memory with a clearing sweep.
// Depends on tzb_pkg.
module tzb_zmem
   import tzb_pkg::*;
#(
   parameter int DEPTH  = TZB_DEPTH,
   parameter int ADDR_W = $clog2(TZB_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [Z_W-1:0]    rd_data,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [Z_W-1:0]    wr_data,
   output logic              ready
);

   logic [Z_W-1:0]    mem [DEPTH];
   logic [Z_W-1:0]    rd_data_ff;
   logic              clr_busy_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic              wr_any;
   logic [ADDR_W-1:0] wr_sel;
   logic [Z_W-1:0]    wr_val;

   // Sweep zeros through every entry after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_busy_ff) begin
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) clr_busy_ff <= 1'b0;
         clr_addr_ff <= clr_addr_ff + 1'b1;
      end
   end

   assign wr_any = clr_busy_ff || wr_en;
   assign wr_sel = clr_busy_ff ? clr_addr_ff : wr_addr;
   assign wr_val = clr_busy_ff ? '0 : wr_data;

   always_ff @(posedge clock) begin
      if (wr_any) mem[wr_sel] <= wr_val;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_busy_ff;

endmodule
